// ===== rtl/bfa_pkg.sv =====
// Shared types and constants for the best-fit block slot allocator.
// No dependencies; compiled first.
`default_nettype none

package bfa_pkg;

  localparam int FREE_SLOTS_DEF  = 64;
  localparam int BLOCK_BYTES_DEF = 1024;

  localparam int OFS_W  = 31;
  localparam int SIZE_W = 31;
  localparam int BLK_W  = 31;
  localparam int NUM_W  = 32;
  localparam int TOT_W  = 37;

  localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_OWNED = 2'd1,
    ST_LIST_FULL = 2'd2,
    ST_NO_SPACE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [OFS_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [BLK_W-1:0]  blocks;
  } slot_t;

endpackage

`default_nettype wire

// ===== rtl/bfa_if.sv =====
// Request and result channel interfaces of the allocator.
// Depends on bfa_pkg.
`default_nettype none

interface bfa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [bfa_pkg::SIZE_W-1:0] byte_size;
  logic [bfa_pkg::OFS_W-1:0]  slot_offset;
  logic                       slot_owned;

  modport source(output valid, mode, byte_size, slot_offset, slot_owned, input ready);
  modport sink(input valid, mode, byte_size, slot_offset, slot_owned, output ready);
endinterface

interface bfa_rsp_if;
  logic                      valid;
  logic                      ready;
  bfa_pkg::status_t          status;
  logic [bfa_pkg::OFS_W-1:0] place_offset;
  logic                      reused_slot;
  logic [bfa_pkg::TOT_W-1:0] free_bytes;

  modport source(output valid, status, place_offset, reused_slot, free_bytes, input ready);
  modport sink(input valid, status, place_offset, reused_slot, free_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfa_ceil_div.sv =====
// Block count unit: ceil(x / DIVISOR) by reciprocal multiplication.
// Depends on bfa_pkg.
`default_nettype none

module bfa_ceil_div #(
  parameter int DIVISOR = bfa_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bfa_pkg::SIZE_W-1:0] dividend,
  output logic                            done,
  output logic [bfa_pkg::BLK_W-1:0]       quot
);
  import bfa_pkg::*;

  // q = floor(n * RECIP / 2^(NUM_W + LG)), exact for any NUM_W-bit n; RECIP < 2^33
  localparam int LG     = $clog2(DIVISOR);
  localparam int LO_W   = 17;
  localparam int HI_W   = 16;
  localparam int FULL_W = NUM_W + LO_W + HI_W;
  localparam longint unsigned RECIP =
    ((64'd1 << (NUM_W + LG)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [LO_W-1:0]  RC_LO = LO_W'(RECIP);
  localparam logic [HI_W-1:0]  RC_HI = HI_W'(RECIP >> LO_W);
  localparam logic [NUM_W-1:0] BIAS  = NUM_W'(DIVISOR - 1);

  logic [NUM_W-1:0]      num_r;
  logic [NUM_W+LO_W-1:0] plo_r;
  logic [BLK_W-1:0]      quo_r;
  logic                  stg1_r, stg2_r, done_r;

  logic [NUM_W+LO_W-1:0] plo;
  logic [NUM_W+HI_W-1:0] phi;
  logic [FULL_W-1:0]     full;

  // low and high halves of the reciprocal in separate cycles
  assign plo  = num_r * RC_LO;
  assign phi  = num_r * RC_HI;
  assign full = {phi, {LO_W{1'b0}}} + FULL_W'(plo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_r <= 1'b0;
      stg2_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg1_r <= start;
      stg2_r <= stg1_r;
      done_r <= stg2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= NUM_W'(dividend) + BIAS;
    end
    if (stg1_r) begin
      plo_r <= plo;
    end
    if (stg2_r) begin
      quo_r <= BLK_W'(full >> (NUM_W + LG));
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

// ===== rtl/bfa_slot_ram.sv =====
// Free list storage: one write port, one read port, registered read data.
// Depends on bfa_pkg.
`default_nettype none

module bfa_slot_ram #(
  parameter int DEPTH = bfa_pkg::FREE_SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire bfa_pkg::slot_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output bfa_pkg::slot_t      rdata
);
  import bfa_pkg::*;

  slot_t mem_r [DEPTH];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/best_fit_block_slot_allocator_core.sv =====
// Best-fit slot allocator top level: request FSM, free list memory, block divider.
// Depends on bfa_pkg, bfa_if, bfa_ceil_div, bfa_slot_ram.
//
// Each request yields one result. A free passes through the block count unit
// and is appended to the list; an unowned free or a free to a full list skips it.
// An allocate runs the block count, then one memory read per slot in the
// best-fit scan; when the chosen slot shrinks it is rewritten, and when an
// exactly used slot at position k is removed the later slots are moved down
// through the memory's separate read and write ports.
// A result that is not taken holds the next one back. The result register lets
// the next request be accepted while a result waits.
`default_nettype none

module best_fit_block_slot_allocator_core #(
  parameter int FREE_SLOTS  = bfa_pkg::FREE_SLOTS_DEF,
  parameter int BLOCK_BYTES = bfa_pkg::BLOCK_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  bfa_req_if.sink    in_req,
  bfa_rsp_if.source  out_rsp
);
  import bfa_pkg::*;

  localparam int AW    = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CNT_W = $clog2(FREE_SLOTS + 1);
  localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
  localparam int PR_W  = BLK_W + BB_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_SLOTS);
  localparam logic [BB_W-1:0]  BB_C     = BB_W'(BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_NEED_MUL, S_SCAN, S_PICK, S_REM_MUL, S_SHRINK, S_COMPACT, S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OFS_W-1:0]  data_end_r, data_end_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [BLK_W-1:0]  need_blk_r, need_blk_nxt;
  logic [NUM_W-1:0]  need_bytes_r, need_bytes_nxt;
  logic [BLK_W-1:0]  rem_blk_r, rem_blk_nxt;
  logic [NUM_W-1:0]  rem_bytes_r, rem_bytes_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [CNT_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              found_r, found_nxt;
  slot_t             best_r, best_nxt;
  logic [CNT_W-1:0]  best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]  mv_rd_r, mv_rd_nxt;
  logic [CNT_W-1:0]  mv_wr_r, mv_wr_nxt;
  logic              mv_vld_r, mv_vld_nxt;
  status_t           status_r, status_nxt;
  logic [OFS_W-1:0]  place_r, place_nxt;
  logic              reused_r, reused_nxt;
  logic              out_vld_r, out_vld_nxt;
  status_t           o_status_r, o_status_nxt;
  logic [OFS_W-1:0]  o_place_r, o_place_nxt;
  logic              o_reused_r, o_reused_nxt;
  logic [TOT_W-1:0]  o_total_r, o_total_nxt;

  logic              div_start, div_done;
  logic [BLK_W-1:0]  div_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  slot_t             ram_wdata, ram_rdata;
  logic [BLK_W-1:0]  mul_a;
  logic [PR_W-1:0]   prod;
  logic [NUM_W:0]    end_sum;
  logic [SIZE_W-1:0] shrink_size;
  logic [OFS_W-1:0]  shrink_ofs;

  bfa_ceil_div #(.DIVISOR(BLOCK_BYTES)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_req.byte_size),
    .done     (div_done),
    .quot     (div_q)
  );

  bfa_slot_ram #(.DEPTH(FREE_SLOTS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mul_a   = (state_r == S_NEED_MUL) ? need_blk_r : rem_blk_r;
  assign prod    = PR_W'(mul_a) * PR_W'(BB_C);
  assign end_sum = (NUM_W + 1)'(data_end_r) + (NUM_W + 1)'(need_bytes_r);
  assign shrink_size = (rem_bytes_r > NUM_W'(OFS_MAX)) ? OFS_MAX : rem_bytes_r[SIZE_W-1:0];
  assign shrink_ofs  = best_r.offset + need_bytes_r[OFS_W-1:0];

  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    size_nxt       = size_r;
    ofs_nxt        = ofs_r;
    cnt_nxt        = cnt_r;
    data_end_nxt   = data_end_r;
    total_nxt      = total_r;
    need_blk_nxt   = need_blk_r;
    need_bytes_nxt = need_bytes_r;
    rem_blk_nxt    = rem_blk_r;
    rem_bytes_nxt  = rem_bytes_r;
    iss_nxt        = iss_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    mv_rd_nxt      = mv_rd_r;
    mv_wr_nxt      = mv_wr_r;
    mv_vld_nxt     = mv_vld_r;
    status_nxt     = status_r;
    place_nxt      = place_r;
    reused_nxt     = reused_r;
    out_vld_nxt    = out_vld_r;
    o_status_nxt   = o_status_r;
    o_place_nxt    = o_place_r;
    o_reused_nxt   = o_reused_r;
    o_total_nxt    = o_total_r;
    div_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = best_r;
    ram_raddr      = iss_r[AW-1:0];

    if (out_vld_r && out_rsp.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          mode_nxt   = in_req.mode;
          size_nxt   = in_req.byte_size;
          ofs_nxt    = in_req.slot_offset;
          status_nxt = ST_OK;
          place_nxt  = '0;
          reused_nxt = 1'b0;
          if (in_req.mode == MODE_FREE && !in_req.slot_owned) begin
            status_nxt = ST_NOT_OWNED;
            state_nxt  = S_FINISH;
          end else if (in_req.mode == MODE_FREE && cnt_r == CNT_FULL) begin
            status_nxt = ST_LIST_FULL;
            state_nxt  = S_FINISH;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (mode_r == MODE_FREE) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[AW-1:0];
            ram_wdata = '{offset: ofs_r, size: size_r, blocks: div_q};
            cnt_nxt   = cnt_r + 1'b1;
            total_nxt = total_r + TOT_W'(size_r);
            state_nxt = S_FINISH;
          end else begin
            need_blk_nxt = div_q;
            state_nxt    = S_NEED_MUL;
          end
        end
      end
      S_NEED_MUL: begin
        need_bytes_nxt = prod[NUM_W-1:0];
        iss_nxt        = '0;
        chk_vld_nxt    = 1'b0;
        found_nxt      = 1'b0;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (iss_r < cnt_r) begin
          iss_nxt     = iss_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r && ram_rdata.blocks >= need_blk_r &&
            (!found_r || ram_rdata.blocks < best_r.blocks)) begin
          found_nxt    = 1'b1;
          best_nxt     = ram_rdata;
          best_idx_nxt = chk_idx_r;
        end
        if (iss_r == cnt_r && !chk_vld_r) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (found_r) begin
          place_nxt   = best_r.offset;
          reused_nxt  = 1'b1;
          total_nxt   = total_r - TOT_W'(best_r.size);
          rem_blk_nxt = best_r.blocks - need_blk_r;
          if (best_r.blocks == need_blk_r) begin
            mv_rd_nxt  = best_idx_r + 1'b1;
            mv_vld_nxt = 1'b0;
            state_nxt  = S_COMPACT;
          end else begin
            state_nxt = S_REM_MUL;
          end
        end else begin
          if (end_sum > (NUM_W + 1)'(OFS_MAX)) begin
            status_nxt = ST_NO_SPACE;
          end else begin
            place_nxt    = data_end_r;
            data_end_nxt = end_sum[OFS_W-1:0];
          end
          state_nxt = S_FINISH;
        end
      end
      S_REM_MUL: begin
        rem_bytes_nxt = prod[NUM_W-1:0];
        state_nxt     = S_SHRINK;
      end
      S_SHRINK: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_r[AW-1:0];
        ram_wdata = '{offset: shrink_ofs, size: shrink_size, blocks: rem_blk_r};
        total_nxt = total_r + TOT_W'(shrink_size);
        state_nxt = S_FINISH;
      end
      S_COMPACT: begin
        ram_raddr = mv_rd_r[AW-1:0];
        if (mv_rd_r < cnt_r) begin
          mv_rd_nxt  = mv_rd_r + 1'b1;
          mv_wr_nxt  = mv_rd_r - 1'b1;
          mv_vld_nxt = 1'b1;
        end else begin
          mv_vld_nxt = 1'b0;
        end
        if (mv_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = mv_wr_r[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (mv_rd_r >= cnt_r && !mv_vld_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_vld_r || out_rsp.ready) begin
          out_vld_nxt  = 1'b1;
          o_status_nxt = status_r;
          o_place_nxt  = place_r;
          o_reused_nxt = reused_r;
          o_total_nxt  = total_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      data_end_r <= '0;
      total_r    <= '0;
      out_vld_r  <= 1'b0;
      chk_vld_r  <= 1'b0;
      mv_vld_r   <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      data_end_r <= data_end_nxt;
      total_r    <= total_nxt;
      out_vld_r  <= out_vld_nxt;
      chk_vld_r  <= chk_vld_nxt;
      mv_vld_r   <= mv_vld_nxt;
      found_r    <= found_nxt;
    end
    mode_r       <= mode_nxt;
    size_r       <= size_nxt;
    ofs_r        <= ofs_nxt;
    need_blk_r   <= need_blk_nxt;
    need_bytes_r <= need_bytes_nxt;
    rem_blk_r    <= rem_blk_nxt;
    rem_bytes_r  <= rem_bytes_nxt;
    iss_r        <= iss_nxt;
    chk_idx_r    <= chk_idx_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    mv_rd_r      <= mv_rd_nxt;
    mv_wr_r      <= mv_wr_nxt;
    status_r     <= status_nxt;
    place_r      <= place_nxt;
    reused_r     <= reused_nxt;
    o_status_r   <= o_status_nxt;
    o_place_r    <= o_place_nxt;
    o_reused_r   <= o_reused_nxt;
    o_total_r    <= o_total_nxt;
  end

  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.status       = o_status_r;
  assign out_rsp.place_offset = o_place_r;
  assign out_rsp.reused_slot  = o_reused_r;
  assign out_rsp.free_bytes   = o_total_r;

endmodule

`default_nettype wire
